/* src/lzss_pkg.sv */
package lzss_pkg;

  // default sizes
  localparam int HISTORY_BITS_DEF = 12;
  localparam int LENGTH_BITS_DEF  = 4;
  localparam int MIN_MATCH_DEF    = 3;

  // commands from controller to datapath
  typedef struct packed {
    logic lit_go;    // literal request taken: emit byte, append to ring
    logic match_go;  // match request taken: latch position and length
    logic rd_en;     // issue one ring read for the current match
    logic wr_en;     // append one staged byte to the ring
  } lzss_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic slot_free;  // output register free this cycle
    logic pending;    // ring read data waiting to be moved to output
    logic load;       // read data moves to output this cycle
    logic rd_more;    // match reads still to issue
    logic ld_last;    // final byte of the match moves to output
    logic wr_last;    // final staged byte is being appended
  } lzss_stat_t;

endpackage

/* src/lzss_ctrl.sv */
module lzss_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  lzss_pkg::lzss_stat_t stat,
  output lzss_pkg::lzss_cmd_t  ctl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  localparam logic CMD_MATCH = 1'b1;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and command decode
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = stat.slot_free;
        if (in_valid && stat.slot_free) begin
          if (cmd == CMD_MATCH) begin
            ctl.match_go = 1'b1;
            state_next   = ST_READ;
          end else begin
            ctl.lit_go = 1'b1;
          end
        end
      end
      ST_READ: begin
        ctl.rd_en = stat.rd_more && (!stat.pending || stat.load);
        if (stat.ld_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ctl.wr_en = 1'b1;
        if (stat.wr_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* src/lzss_dpath.sv */
module lzss_dpath #(
  parameter int HISTORY_BITS = lzss_pkg::HISTORY_BITS_DEF,
  parameter int LENGTH_BITS  = lzss_pkg::LENGTH_BITS_DEF,
  parameter int MIN_MATCH    = lzss_pkg::MIN_MATCH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lzss_pkg::lzss_cmd_t     ctl,
  output lzss_pkg::lzss_stat_t    stat,
  input  logic [7:0]              literal_byte,
  input  logic [HISTORY_BITS-1:0] match_position,
  input  logic [LENGTH_BITS-1:0]  length_code,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    last
);

  localparam int RING_SIZE   = 1 << HISTORY_BITS;
  localparam int STAGE_DEPTH = (1 << LENGTH_BITS) - 1 + MIN_MATCH;
  localparam int CNT_W       = $clog2(STAGE_DEPTH + 1);
  localparam int IDX_W       = $clog2(STAGE_DEPTH);

  // history ring and match staging
  logic [7:0] ring [RING_SIZE];
  logic [7:0] staging [STAGE_DEPTH];

  logic [HISTORY_BITS-1:0] pos;
  logic [CNT_W-1:0]        len;
  logic [CNT_W-1:0]        rd_idx;
  logic [CNT_W-1:0]        ld_idx;
  logic [CNT_W-1:0]        wr_idx;
  logic [HISTORY_BITS-1:0] wp;
  logic                    wrapped;
  logic                    pending;
  logic                    rd_written;
  logic [7:0]              rdata;

  logic                    slot_free;
  logic                    load;
  logic [HISTORY_BITS-1:0] rd_addr;
  logic                    ring_we;
  logic [7:0]              ring_wdata;
  logic [7:0]              rd_byte;

  // output slot and read-to-output transfer
  assign slot_free = !out_valid || out_ready;
  assign load      = pending && slot_free;
  assign rd_addr   = pos + HISTORY_BITS'(rd_idx);
  // entries not yet reached by the write pointer are read as zero
  assign rd_byte   = rd_written ? rdata : 8'd0;

  assign ring_we    = ctl.lit_go || ctl.wr_en;
  assign ring_wdata = ctl.lit_go ? literal_byte : staging[wr_idx[IDX_W-1:0]];

  always_comb begin
    stat.slot_free = slot_free;
    stat.pending   = pending;
    stat.load      = load;
    stat.rd_more   = (rd_idx != len);
    stat.ld_last   = load && ((ld_idx + CNT_W'(1)) == len);
    stat.wr_last   = (wr_idx + CNT_W'(1)) == len;
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wp] <= ring_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata      <= ring[rd_addr];
      rd_written <= wrapped || (rd_addr < wp);
    end
  end

  // staging of copied bytes
  always_ff @(posedge clk) begin
    if (load) begin
      staging[ld_idx[IDX_W-1:0]] <= rd_byte;
    end
  end

  // match parameters
  always_ff @(posedge clk) begin
    if (ctl.match_go) begin
      pos <= match_position;
      len <= CNT_W'(length_code) + CNT_W'(MIN_MATCH);
    end
  end

  // counters and write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      ld_idx  <= '0;
      wr_idx  <= '0;
      wp      <= '0;
      wrapped <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (ctl.match_go) begin
        rd_idx <= '0;
        ld_idx <= '0;
        wr_idx <= '0;
      end else begin
        if (ctl.rd_en) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (load) begin
          ld_idx <= ld_idx + CNT_W'(1);
        end
        if (ctl.wr_en) begin
          wr_idx <= wr_idx + CNT_W'(1);
        end
      end
      if (ctl.rd_en) begin
        pending <= 1'b1;
      end else if (load) begin
        pending <= 1'b0;
      end
      if (ring_we) begin
        wp <= wp + HISTORY_BITS'(1);
        if (wp == {HISTORY_BITS{1'b1}}) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.lit_go || load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lit_go) begin
      out_byte <= literal_byte;
      last     <= 1'b1;
    end else if (load) begin
      out_byte <= rd_byte;
      last     <= (ld_idx + CNT_W'(1)) == len;
    end
  end

  // checks
  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    !(ring_we && ctl.rd_en))
    else $error("ring written while match reads are in flight");

  a_load_bounded: assert property (@(posedge clk) disable iff (rst)
    load |-> (ld_idx < len))
    else $error("match byte moved to output beyond match length");

  a_write_bounded: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> (wr_idx < len) && (ld_idx == len))
    else $error("staged write out of range or before all reads done");

  a_wp_advance: assert property (@(posedge clk) disable iff (rst)
    ring_we |=> wp == $past(wp) + HISTORY_BITS'(1))
    else $error("write pointer did not advance");

endmodule

/* src/lzss_token_decoder.sv */
// Literal request: its byte is at the output on the next cycle after it is taken;
// literals can be taken back to back.
// Match request of L = length_code + MIN_MATCH bytes: ring read register, then output
// register, one byte per cycle unless the output stalls (single ring read port); then the
// L staged bytes are appended to the ring. No new request is taken before that ends.
// Reset: write pointer zero; ring reads as zero until written (wrap flag, no clearing pass).
module lzss_token_decoder #(
  parameter int HISTORY_BITS = lzss_pkg::HISTORY_BITS_DEF,
  parameter int LENGTH_BITS  = lzss_pkg::LENGTH_BITS_DEF,
  parameter int MIN_MATCH    = lzss_pkg::MIN_MATCH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    cmd,
  input  logic [7:0]              literal_byte,
  input  logic [HISTORY_BITS-1:0] match_position,
  input  logic [LENGTH_BITS-1:0]  length_code,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    last
);

  lzss_pkg::lzss_cmd_t  ctl;
  lzss_pkg::lzss_stat_t stat;

  // sequencer
  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat),
    .ctl      (ctl)
  );

  // ring, staging and output register
  lzss_dpath #(
    .HISTORY_BITS (HISTORY_BITS),
    .LENGTH_BITS  (LENGTH_BITS),
    .MIN_MATCH    (MIN_MATCH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .literal_byte   (literal_byte),
    .match_position (match_position),
    .length_code    (length_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last           (last)
  );

endmodule

/* test/lzss_decode_checker.sv */
package lzss_tb_pkg;

  // token kinds carried on cmd
  typedef enum logic {
    TOK_LITERAL = 1'b0,
    TOK_MATCH   = 1'b1
  } token_kind_e;

endpackage

module lzss_decode_checker #(
  parameter int HB = lzss_pkg::HISTORY_BITS_DEF,
  parameter int LB = lzss_pkg::LENGTH_BITS_DEF,
  parameter int MM = lzss_pkg::MIN_MATCH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic          cmd,
  input  logic [7:0]    literal_byte,
  input  logic [HB-1:0] match_position,
  input  logic [LB-1:0] length_code,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic [7:0]    out_byte,
  input  logic          last,
  output int            fail_count,
  output int            pending,
  output int            tokens,
  output int            match_count,
  output int            overlaps,
  output int            wrapped_reads,
  output int            bytes_checked,
  output int            ptr_wraps
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 1 << HB;

  typedef struct packed {
    logic [7:0] data;
    logic       tail;
  } dec_byte_t;

  // predictor state: history image and write pointer
  logic [7:0]    ring_img [RING];
  logic [HB-1:0] wp_img;
  dec_byte_t     decoded_q [$];

  int errs, n_tok, n_match, n_overlap, n_wrap_rd, n_bytes, n_ptr_wrap;

  // one line per mismatch, and count it
  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errs++;
  endtask

  function automatic void ring_append(input logic [7:0] b);
    ring_img[wp_img] = b;
    if (wp_img == '1)
      n_ptr_wrap++;
    wp_img = wp_img + 1'b1;
  endfunction

  // expected bytes of one token, then the history update
  function automatic void decode_token(input logic c, input logic [7:0] lit,
                                       input logic [HB-1:0] pos,
                                       input logic [LB-1:0] lcode);
    logic [7:0]    copied [$];
    logic [HB-1:0] rd;
    dec_byte_t     e;
    int            n;
    n_tok++;
    if (c == lzss_tb_pkg::TOK_LITERAL) begin
      e.data = lit;
      e.tail = 1'b1;
      decoded_q.push_back(e);
      ring_append(lit);
    end else begin
      n_match++;
      n = int'(lcode) + MM;
      if (int'(HB'(wp_img - pos)) < n)
        n_overlap++;
      if (int'(pos) + n > RING)
        n_wrap_rd++;
      // every read sees the ring before this token
      rd = pos;
      for (int i = 0; i < n; i++) begin
        copied.push_back(ring_img[rd]);
        e.data = ring_img[rd];
        e.tail = (i == n - 1);
        decoded_q.push_back(e);
        rd = rd + 1'b1;
      end
      foreach (copied[i])
        ring_append(copied[i]);
    end
  endfunction

  // sample both channels at the edge; outputs first so a fresh token
  // can never cover for a spurious byte
  always @(posedge clk) begin : monitor
    dec_byte_t exp_b;
    if (rst) begin
      foreach (ring_img[i])
        ring_img[i] = 8'h00;
      wp_img = '0;
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          flag_error($sformatf("byte %02h last=%0b with nothing expected", out_byte, last));
        end else begin
          exp_b = decoded_q.pop_front();
          n_bytes++;
          if (out_byte !== exp_b.data)
            flag_error($sformatf("out_byte %02h, expected %02h", out_byte, exp_b.data));
          if (last !== exp_b.tail)
            flag_error($sformatf("last %0b, expected %0b (byte %02h)", last, exp_b.tail,
                                 exp_b.data));
        end
      end
      if (in_valid && in_ready)
        decode_token(cmd, literal_byte, match_position, length_code);
    end
    fail_count    <= errs;
    pending       <= decoded_q.size();
    tokens        <= n_tok;
    match_count   <= n_match;
    overlaps      <= n_overlap;
    wrapped_reads <= n_wrap_rd;
    bytes_checked <= n_bytes;
    ptr_wraps     <= n_ptr_wrap;
  end

endmodule

/* test/tb_lzss_token_decoder.sv */
module tb_lzss_token_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HB           = lzss_pkg::HISTORY_BITS_DEF;
  localparam int LB           = lzss_pkg::LENGTH_BITS_DEF;
  localparam int MM           = lzss_pkg::MIN_MATCH_DEF;
  localparam int MAX_LEN      = (1 << LB) - 1 + MM;
  localparam int DRAIN_CYCLES = 2 * MAX_LEN + 10;
  localparam int STALL_LIMIT  = 2000;
  localparam int RAND_FIRST   = 54;
  localparam int RAND_SECOND  = 40;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic          cmd;
  logic [7:0]    literal_byte;
  logic [HB-1:0] match_position;
  logic [LB-1:0] length_code;
  logic          out_valid;
  logic          out_ready;
  logic [7:0]    out_byte;
  logic          last;

  int fail_count, outstanding, tokens, match_count, overlaps, wrapped_reads;
  int bytes_checked, ptr_wraps;

  // bytes appended so far, used to aim matches at recent history
  int appended;
  int burst_left;
  int idle_cycles;

  lzss_token_decoder u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .literal_byte   (literal_byte),
    .match_position (match_position),
    .length_code    (length_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last           (last)
  );

  lzss_decode_checker #(.HB(HB), .LB(LB), .MM(MM)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .literal_byte   (literal_byte),
    .match_position (match_position),
    .length_code    (length_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last           (last),
    .fail_count     (fail_count),
    .pending        (outstanding),
    .tokens         (tokens),
    .match_count    (match_count),
    .overlaps       (overlaps),
    .wrapped_reads  (wrapped_reads),
    .bytes_checked  (bytes_checked),
    .ptr_wraps      (ptr_wraps)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: no request moving on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d bytes outstanding",
               idle_cycles, outstanding);
      $display("tb_lzss_token_decoder: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output backpressure: ready runs, short stalls, now and then a long one
  initial begin : sink_pacing
    int run_len;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      out_ready <= 1'b0;
      repeat (run_len) @(posedge clk);
    end
  end

  // one request: optional gap, then hold until taken
  task automatic send_token(input lzss_tb_pkg::token_kind_e kind, input logic [7:0] lit,
                            input logic [HB-1:0] pos, input logic [LB-1:0] lcode);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(8, 20);
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      gap = $urandom_range(8, 30);
    end else begin
      gap = $urandom_range(0, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= kind;
    literal_byte   <= lit;
    match_position <= pos;
    length_code    <= lcode;
    do @(posedge clk); while (!in_ready);
    appended += (kind == lzss_tb_pkg::TOK_MATCH) ? int'(lcode) + MM : 1;
  endtask

  // mostly matches into recent history, some overlapping, some anywhere
  task automatic random_token();
    lzss_tb_pkg::token_kind_e kind;
    logic [7:0]               lit;
    logic [HB-1:0]            pos;
    logic [LB-1:0]            lcode;
    int                       pick;
    lit   = 8'($urandom);
    pos   = HB'($urandom);
    lcode = LB'($urandom);
    kind  = ($urandom_range(0, 99) < 65) ? lzss_tb_pkg::TOK_MATCH : lzss_tb_pkg::TOK_LITERAL;
    if (kind == lzss_tb_pkg::TOK_MATCH) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        pos = HB'(appended - $urandom_range(1, (appended > 300) ? 300 : appended + 1));
      else if (pick < 85)
        pos = HB'(appended - $urandom_range(0, MAX_LEN - 1));
      if ($urandom_range(0, 4) == 0)
        lcode = '1;
    end
    send_token(kind, lit, pos, lcode);
  endtask

  // sender steps back until every expected byte is out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    appended   = 0;
    burst_left = 0;
    in_valid       <= 1'b0;
    cmd            <= lzss_tb_pkg::TOK_LITERAL;
    literal_byte   <= 8'h00;
    match_position <= '0;
    length_code    <= '0;
    rst            <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, length extremes, ring edges, overlaps
    send_token(lzss_tb_pkg::TOK_LITERAL, 8'h00, '0, '0);
    send_token(lzss_tb_pkg::TOK_LITERAL, 8'hFF, '1, '1);
    send_token(lzss_tb_pkg::TOK_LITERAL, 8'hA5, HB'('h555), LB'('hA));
    send_token(lzss_tb_pkg::TOK_LITERAL, 8'h5A, HB'('hAAA), LB'('h5));
    send_token(lzss_tb_pkg::TOK_MATCH, 8'h00, '0, '0);             // shortest copy
    send_token(lzss_tb_pkg::TOK_MATCH, 8'hFF, '0, '1);             // longest, past write pointer
    send_token(lzss_tb_pkg::TOK_MATCH, 8'h00, '1, '1);             // read wraps off the ring end
    send_token(lzss_tb_pkg::TOK_MATCH, 8'h33, HB'(appended - 1), '0);
    send_token(lzss_tb_pkg::TOK_MATCH, 8'h00, HB'(appended - 3), '1); // overlapping run
    send_token(lzss_tb_pkg::TOK_MATCH, 8'h00, HB'(appended), '1);     // starts at write pointer
    send_token(lzss_tb_pkg::TOK_LITERAL, 8'h01, '1, '1);
    send_token(lzss_tb_pkg::TOK_LITERAL, 8'h80, '0, '0);
    send_token(lzss_tb_pkg::TOK_MATCH, 8'hC3, HB'('h555), LB'('hA));
    send_token(lzss_tb_pkg::TOK_MATCH, 8'h3C, HB'('hAAA), LB'('h5));
    send_token(lzss_tb_pkg::TOK_MATCH, 8'h7E, HB'(appended - MAX_LEN), '1);
    send_token(lzss_tb_pkg::TOK_MATCH, 8'h00, HB'('hFF0), LB'('h7));
    hold_until_drained();

    repeat (RAND_FIRST) random_token();
    hold_until_drained();

    repeat (RAND_SECOND) random_token();
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d tokens, %0d of them matches (%0d overlapping, %0d wrapping reads)",
             tokens, match_count, overlaps, wrapped_reads);
    $display("summary: %0d bytes compared, write pointer wrapped %0d time(s)",
             bytes_checked, ptr_wraps);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_lzss_token_decoder: clean");
    end else begin
      $display("tb_lzss_token_decoder: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/lzss_pkg.sv
src/lzss_ctrl.sv
src/lzss_dpath.sv
src/lzss_token_decoder.sv
test/lzss_decode_checker.sv
test/tb_lzss_token_decoder.sv
